// File: rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants of the first-fit cell allocator: table geometry, field
// widths, cell encodings and command codes.
// ----------------------------------------------------------------------------
package ffca_pkg;

  // Table geometry.
  localparam int CELLS   = 256;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int CNT_W   = IDX_W + 1;

  // Item field widths.
  localparam int CMD_W   = 2;
  localparam int FIELD_W = 9;

  // A cell holds a signed value: free, busy continuation or block length.
  localparam int ENTRY_W = 10;

  localparam logic [ENTRY_W-1:0] CELL_FREE = '0;
  localparam logic [ENTRY_W-1:0] CELL_BUSY = '1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_FIRST_FIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd2;

  // Reset value of the cell limit register.
  localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(CELLS);

endpackage

// File: rtl/ffca_req_if.sv
// ----------------------------------------------------------------------------
// ffca_req_if
// Request channel of the allocator: command, size and block start.
// ----------------------------------------------------------------------------
interface ffca_req_if;
  import ffca_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FIELD_W-1:0] size_req;
  logic [FIELD_W-1:0] block_start;

  modport source (output valid, output cmd, output size_req, output block_start,
                  input ready);
  modport sink   (input valid, input cmd, input size_req, input block_start,
                  output ready);
endinterface

// File: rtl/ffca_rsp_if.sv
// ----------------------------------------------------------------------------
// ffca_rsp_if
// Result channel of the allocator: block index and failure flag.
// ----------------------------------------------------------------------------
interface ffca_rsp_if;
  import ffca_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] alloc_index;
  logic               failed;

  modport source (output valid, output alloc_index, output failed, input ready);
  modport sink   (input valid, input alloc_index, input failed, output ready);
endinterface

// File: rtl/ffca_cfg_if.sv
// ----------------------------------------------------------------------------
// ffca_cfg_if
// Configuration write channel of the allocator: the cell limit.
// ----------------------------------------------------------------------------
interface ffca_cfg_if;
  import ffca_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] cells_in_use;

  modport source (output valid, output cells_in_use, input ready);
  modport sink   (input valid, input cells_in_use, output ready);
endinterface

// File: rtl/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/first_fit_cell_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator
// Allocates and frees blocks of cells in a table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_i (cmd, size_req, block_start) and each one
// produces exactly one item on out_o (alloc_index, failed). The cell limit is
// written through cfg_i, which is always ready; write it only while the block
// is idle.
// The block works on one request at a time. A first-fit or stack allocation
// streams the table out of the RAM one cell per cycle, then writes the new
// block one cell per cycle. A free reads the block start, then clears its
// cells one per cycle. Rejected or unused commands go straight to the result;
// every table access goes through the single RAM port pair.
// After reset the block runs a clearing pass that writes every cell free;
// in_i.ready stays low until it is done.
// Results wait in an output register. A stalled receiver does not stop the
// next request from being accepted, but that request's result is held back
// until the previous one has been taken.
// ----------------------------------------------------------------------------
module first_fit_cell_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  ffca_req_if.sink   in_i,
  ffca_rsp_if.source out_o,
  ffca_cfg_if.sink   cfg_i
);
  import ffca_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_FREE_CHK = 3'd3;
  localparam logic [2:0] ST_MARK     = 3'd4;
  localparam logic [2:0] ST_WIPE     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);

  logic [2:0]         state_q, state_d;
  logic [FIELD_W-1:0] limit_q, limit_d;       // cell limit register
  logic [FIELD_W-1:0] lim_q, lim_d;           // limit clipped to the table
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [FIELD_W-1:0] size_q, size_d;
  logic [FIELD_W-1:0] start_q, start_d;
  logic [FIELD_W-1:0] end_q, end_d;           // last index the scan looks at
  logic [CNT_W-1:0]   ptr_q, ptr_d;           // read or write address
  logic [CNT_W-1:0]   chk_q, chk_d;           // index of the data now returning
  logic               chk_vld_q, chk_vld_d;
  logic [FIELD_W-1:0] run_q, run_d;           // length of the current free run
  logic [FIELD_W-1:0] cnt_q, cnt_d;           // cells left to write
  logic [FIELD_W-1:0] res_idx_q, res_idx_d;
  logic               res_fail_q, res_fail_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_idx_q, out_idx_d;
  logic               out_fail_q, out_fail_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               in_fire;
  logic               out_load;
  logic [FIELD_W-1:0] lim_now;
  logic               cell_free;
  logic [FIELD_W-1:0] run_next;
  logic               scan_hit;
  logic [FIELD_W-1:0] scan_idx;
  logic               entry_start;

  ffca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_fire           = in_i.valid && in_i.ready;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.alloc_index = out_idx_q;
  assign out_o.failed      = out_fail_q;

  // The limit register may exceed the table; such values act as the table size.
  assign lim_now = (limit_q > FIELD_W'(CELLS)) ? FIELD_W'(CELLS) : limit_q;

  // Scan evaluation of the cell returned by the RAM this cycle. A stack
  // allocation stops at the first free cell; first fit waits until the free
  // run is long enough and reports where the run began.
  assign cell_free   = (ram_rdata == CELL_FREE);
  assign run_next    = cell_free ? run_q + FIELD_W'(1) : '0;
  assign scan_hit    = chk_vld_q && cell_free &&
                       ((cmd_q == CMD_STACK) || (run_next >= size_q));
  assign scan_idx    = (cmd_q == CMD_STACK) ? FIELD_W'(chk_q)
                                            : FIELD_W'(chk_q) + FIELD_W'(1) - size_q;
  // A block start holds a positive length.
  assign entry_start = !ram_rdata[ENTRY_W-1] && (ram_rdata != CELL_FREE);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    lim_d       = lim_q;
    cmd_d       = cmd_q;
    size_d      = size_q;
    start_d     = start_q;
    end_d       = end_q;
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    chk_vld_d   = chk_vld_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    res_idx_d   = res_idx_q;
    res_fail_d  = res_fail_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_fail_d  = out_fail_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[IDX_W-1:0];
    ram_wdata   = CELL_FREE;
    ram_raddr   = ptr_q[IDX_W-1:0];

    if (cfg_i.valid) begin
      limit_d = cfg_i.cells_in_use;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + CNT_W'(1);
        if (ptr_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = in_i.block_start[IDX_W-1:0];
        if (in_fire) begin
          cmd_d     = in_i.cmd;
          size_d    = in_i.size_req;
          start_d   = in_i.block_start;
          lim_d     = lim_now;
          ptr_d     = '0;
          chk_vld_d = 1'b0;
          run_d     = '0;
          case (in_i.cmd)
            CMD_FIRST_FIT, CMD_STACK: begin
              if ((in_i.size_req == '0) || (in_i.size_req > lim_now)) begin
                res_idx_d  = lim_now;
                res_fail_d = 1'b1;
                state_d    = ST_DONE;
              end else begin
                end_d   = (in_i.cmd == CMD_STACK) ? lim_now - in_i.size_req
                                                  : lim_now - FIELD_W'(1);
                state_d = ST_SCAN;
              end
            end
            CMD_FREE: begin
              res_idx_d  = in_i.block_start;
              res_fail_d = 1'b0;
              // The read of the start cell is already under way.
              state_d    = (in_i.block_start < lim_now) ? ST_FREE_CHK : ST_DONE;
            end
            default: begin
              res_idx_d  = '0;
              res_fail_d = 1'b0;
              state_d    = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // One read issued per cycle; the data for chk_q returns meanwhile.
        ptr_d     = ptr_q + CNT_W'(1);
        chk_d     = ptr_q;
        chk_vld_d = 1'b1;
        if (chk_vld_q) begin
          run_d = run_next;
          if (scan_hit) begin
            res_idx_d  = scan_idx;
            res_fail_d = 1'b0;
            ptr_d      = CNT_W'(scan_idx);
            cnt_d      = size_q;
            state_d    = ST_MARK;
          end else if (FIELD_W'(chk_q) == end_q) begin
            res_idx_d  = lim_q;
            res_fail_d = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end

      ST_FREE_CHK: begin
        if (entry_start) begin
          ptr_d   = CNT_W'(start_q);
          cnt_d   = ram_rdata[FIELD_W-1:0];
          state_d = ST_WIPE;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_MARK: begin
        // The block start takes the length, the rest become busy.
        ram_we    = 1'b1;
        ram_wdata = (FIELD_W'(ptr_q) == res_idx_q) ? ENTRY_W'(size_q) : CELL_BUSY;
        ptr_d     = ptr_q + CNT_W'(1);
        cnt_d     = cnt_q - FIELD_W'(1);
        if (cnt_q == FIELD_W'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_WIPE: begin
        // Clearing stops at the block's end or the end of the table.
        ram_we = 1'b1;
        ptr_d  = ptr_q + CNT_W'(1);
        cnt_d  = cnt_q - FIELD_W'(1);
        if ((cnt_q == FIELD_W'(1)) || (ptr_q == LAST_CELL)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_fail_d  = res_fail_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      limit_q     <= LIMIT_RESET;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      ptr_q       <= ptr_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    cmd_q      <= cmd_d;
    size_q     <= size_d;
    start_q    <= start_d;
    end_q      <= end_d;
    chk_q      <= chk_d;
    run_q      <= run_d;
    cnt_q      <= cnt_d;
    res_idx_q  <= res_idx_d;
    res_fail_q <= res_fail_d;
    out_idx_q  <= out_idx_d;
    out_fail_q <= out_fail_d;
  end

  // The table is only written while clearing, marking or wiping a block.
  a_write_only_in_update: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_MARK || state_q == ST_WIPE))
    else $error("table written outside an update state");

  // A block being marked never reaches past the clipped limit.
  a_mark_within_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> (FIELD_W'(ptr_q) < lim_q))
    else $error("allocation marks a cell beyond the limit");

  // Only allocations can report a failure.
  a_fail_only_alloc: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_fail_q) |-> (cmd_q == CMD_FIRST_FIT || cmd_q == CMD_STACK))
    else $error("failure reported for a non-allocation command");

endmodule
